// File: rtl/dmpid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmpid_pkg
// Shared types, register codes, constants and helpers of the PID controller.
// ----------------------------------------------------------------------------
package dmpid_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic signed [33:0] HALF_TURN = 34'sd11796480;
  localparam logic signed [33:0] FULL_TURN = 34'sd23592960;

  localparam logic signed [33:0] ERR_MAX = 34'sd2147483647;
  localparam logic signed [33:0] ERR_MIN = -34'sd2147483648;

  localparam logic [23:0] GAIN_P_RST = 24'd65536;
  localparam logic [30:0] OUT_LIM_RST = 31'd65536000;

  typedef enum logic [7:0] {
    REG_MODE     = 8'd0,
    REG_WRAP     = 8'd1,
    REG_GAIN_P   = 8'd2,
    REG_GAIN_I   = 8'd3,
    REG_GAIN_D   = 8'd4,
    REG_INT_LIM  = 8'd5,
    REG_OUT_LIM  = 8'd6,
    REG_DEADBAND = 8'd7
  } reg_idx_t;

  typedef struct packed {
    logic        mode_incremental;
    logic        wrap_enable;
    logic [23:0] gain_p;
    logic [23:0] gain_i;
    logic [23:0] gain_d;
    logic [30:0] integral_limit;
    logic [30:0] output_limit;
    logic [30:0] dead_band;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic signed [31:0] err;
    logic               sat_hit;
    logic               tgt_zero;
    logic               tgt_neg;
  } item_t;

  // Q26.32 product to Q26.16, nearest with ties up
  function automatic logic signed [41:0] round_q16(input logic signed [57:0] p);
    logic signed [57:0] t;
    t = p + 58'sd32768;
    return t[57:16];
  endfunction

endpackage

// File: rtl/dmpid_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmpid_front
// Accepts items, applies the angle wrap, saturates the error and applies
// the dead band; the classified item is offered to the queue.
// ----------------------------------------------------------------------------
module dmpid_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dmpid_pkg::cfg_t       cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [31:0]    in_target,
  input  logic signed [31:0]    in_feedback,
  output logic                  push,
  input  logic                  push_ready,
  output dmpid_pkg::item_t      push_item
);

  logic               s1_valid_r, s1_valid_nxt;
  logic signed [33:0] s1_err_r;
  logic               s1_zero_r;
  logic               s1_neg_r;

  logic signed [33:0] raw;
  logic signed [33:0] err_wrap;
  logic               accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = !s1_valid_r || push_ready;
  assign push     = s1_valid_r && push_ready;

  assign raw = 34'(in_target) - 34'(in_feedback);

  always_comb begin
    err_wrap = raw;
    if (cfg.wrap_enable) begin
      if (raw > dmpid_pkg::HALF_TURN) begin
        err_wrap = raw - dmpid_pkg::FULL_TURN;
      end else if (raw < -dmpid_pkg::HALF_TURN) begin
        err_wrap = raw + dmpid_pkg::FULL_TURN;
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_err_r  <= err_wrap;
      s1_zero_r <= (in_target == 32'sd0);
      s1_neg_r  <= in_target[31];
    end
  end

  logic signed [31:0] err_sat;
  logic               sat_hit;
  logic        [31:0] err_mag;

  always_comb begin
    sat_hit = 1'b0;
    err_sat = s1_err_r[31:0];
    if (s1_err_r > dmpid_pkg::ERR_MAX) begin
      sat_hit = 1'b1;
      err_sat = dmpid_pkg::ERR_MAX[31:0];
    end else if (s1_err_r < dmpid_pkg::ERR_MIN) begin
      sat_hit = 1'b1;
      err_sat = dmpid_pkg::ERR_MIN[31:0];
    end
    err_mag = err_sat[31] ? (32'd0 - err_sat) : err_sat;
    push_item.err      = (err_mag < {1'b0, cfg.dead_band}) ? 32'sd0 : err_sat;
    push_item.sat_hit  = sat_hit;
    push_item.tgt_zero = s1_zero_r;
    push_item.tgt_neg  = s1_neg_r;
  end

endmodule

// File: rtl/dmpid_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmpid_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module dmpid_queue #(
  parameter int DEPTH = dmpid_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              push_ready,
  input  dmpid_pkg::item_t  push_item,
  input  logic              pop,
  output logic              not_empty,
  output dmpid_pkg::item_t  head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dmpid_pkg::item_t mem [DEPTH];

  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign push_ready = (count_r != CW'(DEPTH));
  assign not_empty  = (count_r != '0);
  assign head       = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/dmpid_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmpid_back
// PID sequencer: one shared multiplier forms the i, p and d products in
// turn, then the drive is summed, clamped and registered for output.
// ----------------------------------------------------------------------------
module dmpid_back (
  input  logic               clk,
  input  logic               rst_n,
  input  dmpid_pkg::cfg_t    cfg,
  input  logic               not_empty,
  input  dmpid_pkg::item_t   head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_drive,
  output logic               out_limited
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_I,
    S_MUL_P,
    S_MUL_D,
    S_SUM,
    S_ZERO
  } state_t;

  state_t             state_r, state_nxt;
  logic signed [31:0] err_r;
  logic               sat_r;
  logic               neg_r;
  logic signed [57:0] prod_r, prod_nxt;
  logic signed [44:0] acc_r, acc_nxt;
  logic signed [31:0] last_error_r, last_error_nxt;
  logic signed [31:0] integral_r, integral_nxt;
  logic signed [31:0] held_r, held_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_drive_r, out_drive_nxt;
  logic               out_limited_r, out_limited_nxt;

  logic               out_free;
  logic               finish;
  logic signed [32:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [41:0] prod_rnd;
  logic signed [42:0] isum;
  logic signed [42:0] ilim;
  logic signed [45:0] total;
  logic signed [45:0] lo;
  logic signed [45:0] hi;
  logic signed [45:0] olim;
  logic               hit;
  logic signed [31:0] drive;

  assign out_valid   = out_valid_r;
  assign out_drive   = out_drive_r;
  assign out_limited = out_limited_r;

  assign out_free = !out_valid_r || out_ready;
  assign finish   = ((state_r == S_SUM) || (state_r == S_ZERO)) && out_free;
  assign pop      = not_empty && ((state_r == S_IDLE) || finish);

  always_comb begin
    mul_a = 33'(err_r);
    mul_b = $signed({1'b0, cfg.gain_i});
    case (state_r)
      S_MUL_P: mul_b = $signed({1'b0, cfg.gain_p});
      S_MUL_D: begin
        mul_a = 33'(err_r) - 33'(last_error_r);
        mul_b = $signed({1'b0, cfg.gain_d});
      end
      default: ;
    endcase
  end

  assign prod_nxt = mul_a * mul_b;
  assign prod_rnd = dmpid_pkg::round_q16(prod_r);

  // i-term update and final sum
  assign ilim  = $signed({12'd0, cfg.integral_limit});
  assign isum  = 43'(integral_r) + 43'(prod_rnd);
  assign total = 46'(acc_r) + 46'(prod_rnd);
  assign olim  = $signed({15'd0, cfg.output_limit});

  always_comb begin
    if (!cfg.mode_incremental) begin
      lo = -olim;
      hi = olim;
    end else if (neg_r) begin
      lo = -olim;
      hi = 46'sd0;
    end else begin
      lo = 46'sd0;
      hi = olim;
    end
    hit   = 1'b0;
    drive = total[31:0];
    if (total < lo) begin
      hit   = 1'b1;
      drive = lo[31:0];
    end else if (total > hi) begin
      hit   = 1'b1;
      drive = hi[31:0];
    end
  end

  always_comb begin
    state_nxt       = state_r;
    acc_nxt         = acc_r;
    last_error_nxt  = last_error_r;
    integral_nxt    = integral_r;
    held_nxt        = held_r;
    out_valid_nxt   = out_valid_r;
    out_drive_nxt   = out_drive_r;
    out_limited_nxt = out_limited_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: ;
      S_MUL_I: state_nxt = S_MUL_P;
      S_MUL_P: begin
        if (isum > ilim) begin
          integral_nxt = ilim[31:0];
        end else if (isum < -ilim) begin
          integral_nxt = 32'(-ilim);
        end else begin
          integral_nxt = isum[31:0];
        end
        state_nxt = S_MUL_D;
      end
      S_MUL_D: begin
        acc_nxt = 45'(prod_rnd) + 45'(integral_r)
                + (cfg.mode_incremental ? 45'(held_r) : 45'sd0);
        state_nxt = S_SUM;
      end
      S_SUM: begin
        if (out_free) begin
          last_error_nxt  = err_r;
          held_nxt        = drive;
          out_valid_nxt   = 1'b1;
          out_drive_nxt   = drive;
          out_limited_nxt = hit || sat_r;
          state_nxt       = S_IDLE;
        end
      end
      S_ZERO: begin
        if (out_free) begin
          last_error_nxt  = err_r;
          integral_nxt    = 32'sd0;
          held_nxt        = 32'sd0;
          out_valid_nxt   = 1'b1;
          out_drive_nxt   = 32'sd0;
          out_limited_nxt = 1'b0;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (pop) begin
      state_nxt = (cfg.mode_incremental && head.tgt_zero) ? S_ZERO : S_MUL_I;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      last_error_r <= '0;
      integral_r   <= '0;
      held_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      last_error_r <= last_error_nxt;
      integral_r   <= integral_nxt;
      held_r       <= held_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      err_r <= head.err;
      sat_r <= head.sat_hit;
      neg_r <= head.tgt_neg;
    end
    if ((state_r == S_MUL_I) || (state_r == S_MUL_P) || (state_r == S_MUL_D)) begin
      prod_r <= prod_nxt;
    end
    acc_r         <= acc_nxt;
    out_drive_r   <= out_drive_nxt;
    out_limited_r <= out_limited_nxt;
  end

endmodule

// File: rtl/dual_mode_pid_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_mode_pid_controller_unit
// Positional / incremental PID controller on signed Q16.16 samples.
// ----------------------------------------------------------------------------
// Items enter a one-stage registered front end (wrap, error saturation, dead
// band) and wait in a short queue for the back end, which shares one 33x25
// multiplier over the integral, proportional and derivative products, then
// forms the final sum and clamp, and takes the next item as it finishes one.
// An incremental item with a zero target skips the products and gives a zero
// drive. The input stays ready while results wait, until the front stage and
// queue fill. Registers are to be written by the user through the cfg port
// only while the block is idle; the block itself does not enforce it.
// cfg_ready is always high and writes to unknown indexes are ignored.
// ----------------------------------------------------------------------------
module dual_mode_pid_controller_unit #(
  parameter int QUEUE_DEPTH = dmpid_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_target,
  input  logic signed [31:0] in_feedback,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_drive,
  output logic               out_limited,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  dmpid_pkg::cfg_t  cfg_r;
  dmpid_pkg::item_t push_item;
  dmpid_pkg::item_t head;
  logic             push;
  logic             push_ready;
  logic             pop;
  logic             not_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode_incremental <= 1'b0;
      cfg_r.wrap_enable      <= 1'b0;
      cfg_r.gain_p           <= dmpid_pkg::GAIN_P_RST;
      cfg_r.gain_i           <= '0;
      cfg_r.gain_d           <= '0;
      cfg_r.integral_limit   <= '0;
      cfg_r.output_limit     <= dmpid_pkg::OUT_LIM_RST;
      cfg_r.dead_band        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dmpid_pkg::REG_MODE:     cfg_r.mode_incremental <= cfg_data[0];
        dmpid_pkg::REG_WRAP:     cfg_r.wrap_enable      <= cfg_data[0];
        dmpid_pkg::REG_GAIN_P:   cfg_r.gain_p           <= cfg_data[23:0];
        dmpid_pkg::REG_GAIN_I:   cfg_r.gain_i           <= cfg_data[23:0];
        dmpid_pkg::REG_GAIN_D:   cfg_r.gain_d           <= cfg_data[23:0];
        dmpid_pkg::REG_INT_LIM:  cfg_r.integral_limit   <= cfg_data[30:0];
        dmpid_pkg::REG_OUT_LIM:  cfg_r.output_limit     <= cfg_data[30:0];
        dmpid_pkg::REG_DEADBAND: cfg_r.dead_band        <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  dmpid_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_target   (in_target),
    .in_feedback (in_feedback),
    .push        (push),
    .push_ready  (push_ready),
    .push_item   (push_item)
  );

  dmpid_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop        (pop),
    .not_empty  (not_empty),
    .head       (head)
  );

  dmpid_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .not_empty   (not_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_drive   (out_drive),
    .out_limited (out_limited)
  );

endmodule

// File: rtl/dmpid_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmpid_checker
// Port-level checks of the PID controller, bound to the top level.
// ----------------------------------------------------------------------------
module dmpid_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_drive,
  input logic               out_limited,
  input logic               cfg_valid,
  input logic               cfg_ready
);

  // a held result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive) && $stable(out_limited))
    else $error("result changed while stalled");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // the clamp bound is at most 2^31-1, so the most negative code never shows
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_drive != -32'sd2147483648)
    else $error("drive outside clamp range");

  // the configuration port never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind dual_mode_pid_controller_unit dmpid_checker u_dmpid_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dual-mode PID controller. Setpoint/feedback
// samples go in through a valid/ready driver that is fed from a queue. A
// per-sample shadow of the controller state predicts each drive and limit
// flag, and the outputs are checked in order. The registers are reprogrammed
// between phases while the block is idle. Directed corners come first:
// saturation, angle wrap, dead band, mode change and zero target. Randomized
// setpoint tracking phases follow, random stalls on both sides in all but one.
// ----------------------------------------------------------------------------
module tb_top;
  import dmpid_pkg::*;

  localparam int          Q1          = 65536;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [7:0]  REG_UNUSED  = 8'd8;

  typedef struct {
    logic signed [31:0] target;
    logic signed [31:0] feedback;
  } sample_t;

  typedef struct {
    logic signed [31:0] drive;
    logic               limited;
  } drive_res_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_target = '0;
  logic signed [31:0] in_feedback = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_drive;
  logic               out_limited;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [7:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  sample_t     sample_q[$];
  drive_res_t  expected_drives[$];
  bit          send_busy = 1'b0;
  bit          in_taken = 1'b0;
  bit          cfg_taken = 1'b0;
  int          gap_pct = 33;
  int          fail_cnt = 0;
  int          setpoint = 0;
  int unsigned cycle_cnt = 0;

  // shadow of the controller
  cfg_t   ctl_cfg;
  longint err_prev;
  longint iterm_acc;
  longint drive_hold;

  dual_mode_pid_controller_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_target   (in_target),
    .in_feedback (in_feedback),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_drive   (out_drive),
    .out_limited (out_limited),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint gain_prod(input longint v, input logic [23:0] g);
    longint gl;
    gl = g;
    return (v * gl + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi,
                                  inout bit hit);
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    return v;
  endfunction

  function automatic drive_res_t calc_drive(input logic signed [31:0] tgt_in,
                                            input logic signed [31:0] fb_in);
    drive_res_t res;
    longint     tgt, fb, err, mag, sum, drv, ilim, olim, dband;
    bit         hit, ihit;
    tgt   = tgt_in;
    fb    = fb_in;
    ilim  = ctl_cfg.integral_limit;
    olim  = ctl_cfg.output_limit;
    dband = ctl_cfg.dead_band;
    hit   = 1'b0;
    ihit  = 1'b0;
    if (ctl_cfg.wrap_enable) begin
      if (tgt - fb > HALF_TURN) fb += FULL_TURN;
      else if (tgt - fb < -HALF_TURN) fb -= FULL_TURN;
    end
    err = clip(tgt - fb, ERR_MIN, ERR_MAX, hit);
    mag = (err < 0) ? -err : err;
    if (mag < dband) err = 0;
    // brake: zero target in incremental mode
    if (ctl_cfg.mode_incremental && tgt == 0) begin
      iterm_acc   = 0;
      err_prev    = err;
      drive_hold  = 0;
      res.drive   = '0;
      res.limited = 1'b0;
      return res;
    end
    iterm_acc = clip(iterm_acc + gain_prod(err, ctl_cfg.gain_i), -ilim, ilim, ihit);
    sum = gain_prod(err, ctl_cfg.gain_p) + iterm_acc
        + gain_prod(err - err_prev, ctl_cfg.gain_d);
    if (ctl_cfg.mode_incremental) begin
      sum += drive_hold;
      if (tgt > 0) drv = clip(sum, 0, olim, hit);
      else drv = clip(sum, -olim, 0, hit);
    end else begin
      drv = clip(sum, -olim, olim, hit);
    end
    err_prev    = err;
    drive_hold  = drv;
    res.drive   = drv[31:0];
    res.limited = hit;
    return res;
  endfunction

  // input driver
  always @(negedge clk) begin
    sample_t nxt;
    if (in_taken) begin
      send_busy = 1'b0;
      in_taken  = 1'b0;
    end
    if (!send_busy && sample_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
      nxt = sample_q.pop_front();
      in_target   <= nxt.target;
      in_feedback <= nxt.feedback;
      send_busy = 1'b1;
    end
    in_valid <= send_busy;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= gap_pct);
  end

  // monitor: check results, predict on accept, mirror register writes
  always @(posedge clk) begin
    drive_res_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_drives.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected item: drive %0d limited %0b", out_drive, out_limited);
        end else begin
          want = expected_drives.pop_front();
          if (out_drive !== want.drive || out_limited !== want.limited) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("drive mismatch: exp %0d/%0b got %0d/%0b",
                       want.drive, want.limited, out_drive, out_limited);
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_drives.push_back(calc_drive(in_target, in_feedback));
        in_taken = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:     ctl_cfg.mode_incremental = cfg_data[0];
          REG_WRAP:     ctl_cfg.wrap_enable      = cfg_data[0];
          REG_GAIN_P:   ctl_cfg.gain_p           = cfg_data[23:0];
          REG_GAIN_I:   ctl_cfg.gain_i           = cfg_data[23:0];
          REG_GAIN_D:   ctl_cfg.gain_d           = cfg_data[23:0];
          REG_INT_LIM:  ctl_cfg.integral_limit   = cfg_data[30:0];
          REG_OUT_LIM:  ctl_cfg.output_limit     = cfg_data[30:0];
          REG_DEADBAND: ctl_cfg.dead_band        = cfg_data[30:0];
          default: ;
        endcase
        cfg_taken = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("dual_mode_pid_controller_unit: mismatch");
      $finish;
    end
  end

  // called at a falling edge; leaves cfg_valid high for a following write
  task automatic set_reg(input logic [7:0] idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_taken);
    cfg_taken = 1'b0;
  endtask

  function automatic logic [31:0] with_junk(input logic [31:0] val, input int w);
    logic [31:0] junk;
    junk = $urandom;
    if ($urandom_range(1)) return val;
    return (junk & ~((32'd1 << w) - 32'd1)) | val;
  endfunction

  task automatic program_regs(input int kind);
    logic        md, wr;
    logic [31:0] gp, gi, gd, il, ol, db;
    if (kind == 0) begin
      md = 1'b1; wr = 1'b1;
      gp = 32'hFFFFFF; gi = 32'hFFFFFF; gd = 32'hFFFFFF;
      il = 32'h7FFFFFFF; ol = 32'h7FFFFFFF; db = '0;
    end else if (kind == 1) begin
      md = 1'b0; wr = 1'b0;
      gp = '0; gi = '0; gd = '0;
      il = '0; ol = '0; db = 32'h7FFFFFFF;
    end else begin
      md = $urandom_range(1);
      wr = $urandom_range(1);
      gp = ($urandom_range(9) < 7) ? $urandom_range(0, 4 * Q1) : ($urandom & 32'hFFFFFF);
      gi = ($urandom_range(9) < 7) ? $urandom_range(0, Q1) : ($urandom & 32'hFFFFFF);
      gd = ($urandom_range(9) < 7) ? $urandom_range(0, 2 * Q1) : ($urandom & 32'hFFFFFF);
      il = ($urandom_range(9) < 7) ? $urandom_range(0, 500 * Q1) : ($urandom & 32'h7FFFFFFF);
      ol = ($urandom_range(9) < 7) ? $urandom_range(0, 2000 * Q1) : ($urandom & 32'h7FFFFFFF);
      case ($urandom_range(9))
        0, 1, 2, 3, 4: db = '0;
        9:             db = $urandom & 32'h7FFFFFFF;
        default:       db = $urandom_range(0, Q1);
      endcase
    end
    set_reg(REG_UNUSED | 8'($urandom), $urandom);
    set_reg(REG_MODE, with_junk(32'(md), 1));
    set_reg(REG_WRAP, with_junk(32'(wr), 1));
    set_reg(REG_GAIN_P, with_junk(gp, 24));
    set_reg(REG_GAIN_I, with_junk(gi, 24));
    set_reg(REG_GAIN_D, with_junk(gd, 24));
    set_reg(REG_INT_LIM, with_junk(il, 31));
    set_reg(REG_OUT_LIM, with_junk(ol, 31));
    set_reg(REG_DEADBAND, with_junk(db, 31));
    cfg_valid <= 1'b0;
  endtask

  function automatic void queue_sample(input int t, input int f);
    sample_q.push_back('{target: t, feedback: f});
  endfunction

  // setpoint tracking with wrap, brake and dead band corners, plus raw noise
  function automatic void add_random_sample();
    int t, f, db, r;
    r = $urandom_range(99);
    if ($urandom_range(9) == 0) setpoint = int'($urandom_range(0, 600 * Q1)) - 300 * Q1;
    t = setpoint;
    if (r < 50) begin
      f = t + int'($urandom_range(0, 40 * Q1)) - 20 * Q1;
    end else if (r < 65) begin
      f = t + ($urandom_range(1) ? 180 * Q1 : -180 * Q1) + int'($urandom_range(0, 4)) - 2;
    end else if (r < 75) begin
      t = 0;
      f = int'($urandom_range(0, 20 * Q1)) - 10 * Q1;
    end else if (r < 85) begin
      db = ctl_cfg.dead_band;
      f = t + ($urandom_range(1) ? db : -db) + int'($urandom_range(0, 2)) - 1;
    end else begin
      t = $urandom;
      f = $urandom;
    end
    queue_sample(t, f);
  endfunction

  task automatic drain;
    while (sample_q.size() != 0 || send_busy || expected_drives.size() != 0)
      @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  initial begin
    ctl_cfg                  = '0;
    ctl_cfg.gain_p           = GAIN_P_RST;
    ctl_cfg.output_limit     = OUT_LIM_RST;
    err_prev                 = 0;
    iterm_acc                = 0;
    drive_hold               = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: positional, unity kp, 1000.0 drive bound
    queue_sample(0, 0);
    queue_sample(1000 * Q1, 0);
    queue_sample(1000 * Q1 + 1, 0);
    queue_sample(-1000 * Q1, 0);
    queue_sample(32'h7FFFFFFF, 32'h80000000);
    queue_sample(32'h80000000, 32'h7FFFFFFF);
    queue_sample(32'h80000000, 32'h80000000);
    queue_sample(1, 0);
    queue_sample(-1, 0);
    drain();

    // incremental with wrap, all gains, dead band
    set_reg(REG_MODE, 32'd1);
    set_reg(REG_WRAP, 32'd1);
    set_reg(REG_GAIN_P, 32'h8000);
    set_reg(REG_GAIN_I, 32'h4000);
    set_reg(REG_GAIN_D, 32'h20000);
    set_reg(REG_INT_LIM, 3 * Q1);
    set_reg(REG_OUT_LIM, 50 * Q1);
    set_reg(REG_DEADBAND, Q1 / 2);
    cfg_valid <= 1'b0;
    queue_sample(170 * Q1, -170 * Q1);
    queue_sample(10 * Q1, 0);
    queue_sample(10 * Q1, 0);
    queue_sample(0, 5 * Q1);
    queue_sample(-170 * Q1, 170 * Q1);
    queue_sample(-10 * Q1, 0);
    queue_sample(180 * Q1, 0);
    queue_sample(180 * Q1 + 1, 0);
    queue_sample(5 * Q1 + Q1 / 4, 5 * Q1);
    queue_sample(5 * Q1 + Q1 / 2, 5 * Q1);
    queue_sample(32'h7FFFFFFF, 32'h80000000);
    queue_sample(32'h80000000, 32'h7FFFFFFF);
    queue_sample(0, 32'h80000000);
    drain();

    // back to positional; last error carries over, zero target is ordinary
    set_reg(REG_MODE, 32'd0);
    cfg_valid <= 1'b0;
    queue_sample(0, 5 * Q1);
    queue_sample(-3 * Q1, 0);
    drain();

    for (int p = 0; p < 12; p++) begin
      program_regs((p < 2) ? p : 2);
      gap_pct  = (p == 5) ? 0 : 33;
      setpoint = int'($urandom_range(0, 600 * Q1)) - 300 * Q1;
      for (int k = 0; k < 94; k++) add_random_sample();
      drain();
    end

    if (fail_cnt == 0 && expected_drives.size() == 0) begin
      $display("dual_mode_pid_controller_unit: match");
    end else begin
      $display("dual_mode_pid_controller_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/dmpid_pkg.sv
rtl/dmpid_front.sv
rtl/dmpid_queue.sv
rtl/dmpid_back.sv
rtl/dual_mode_pid_controller_unit.sv
rtl/dmpid_checker.sv
tb/tb_top.sv
